// ----- src/plti_pkg.sv -----
package plti_pkg;

    // Fixed-point formats
    localparam int IN_FRAC_BITS  = 8;
    localparam int OUT_FRAC_BITS = 16;

    // Port widths
    localparam int ALT_W = 32;
    localparam int OUT_W = 25;

    // Breakpoint altitude: whole meters below 2^16, plus sign, plus fraction
    localparam int DOM_W = 17 + IN_FRAC_BITS;
    // Signed compare width covering both the altitude and a breakpoint
    localparam int CMP_W = (DOM_W > ALT_W) ? DOM_W : ALT_W;
    // Table value: at most 340 in whole units
    localparam int RNG_W = 9 + OUT_FRAC_BITS;
    // Result width before the output truncation
    localparam int WIDE_W = (RNG_W > OUT_W) ? RNG_W : OUT_W;
    // Value step across one segment: at most 19 whole units
    localparam int MAG_W = 5 + OUT_FRAC_BITS;
    // Segment length: at most 10000 m
    localparam int DD_W  = 14 + IN_FRAC_BITS;
    // Step times offset
    localparam int PROD_W = MAG_W + DD_W;
    // Divider step counter
    localparam int CNT_W  = $clog2(MAG_W + 1);

    // Table geometry
    localparam int GRAV_N  = 14;
    localparam int SOUND_N = 16;
    localparam int IDX_W   = 4;

    // Table select codes
    localparam logic SEL_GRAV  = 1'b0;
    localparam logic SEL_SOUND = 1'b1;

    // Gravity in thousandths of m/s^2, rounded to the output format
    function automatic logic [RNG_W-1:0] grav_q(input longint unsigned milli);
        longint unsigned scaled;
        scaled = ((milli << OUT_FRAC_BITS) + 64'd500) / 64'd1000;
        return RNG_W'(scaled);
    endfunction

    // Sound speed in whole m/s to the output format
    function automatic logic [RNG_W-1:0] sound_q(input longint unsigned mps);
        return RNG_W'(mps << OUT_FRAC_BITS);
    endfunction

    localparam int GRAV_ALT [GRAV_N] = '{
        0, 1000, 2000, 3000, 4000, 5000, 6000, 7000, 8000, 9000, 10000,
        15000, 20000, 25000
    };

    localparam logic [RNG_W-1:0] GRAV_RNG [GRAV_N] = '{
        grav_q(9807), grav_q(9804), grav_q(9801), grav_q(9797), grav_q(9794),
        grav_q(9791), grav_q(9788), grav_q(9785), grav_q(9782), grav_q(9779),
        grav_q(9776), grav_q(9761), grav_q(9745), grav_q(9730)
    };

    localparam int SOUND_ALT [SOUND_N] = '{
        0, 1000, 2000, 3000, 4000, 5000, 6000, 7000, 8000, 9000, 10000,
        15000, 20000, 25000, 30000, 40000
    };

    localparam logic [RNG_W-1:0] SOUND_RNG [SOUND_N] = '{
        sound_q(340), sound_q(336), sound_q(332), sound_q(328), sound_q(324),
        sound_q(320), sound_q(316), sound_q(312), sound_q(308), sound_q(303),
        sound_q(299), sound_q(295), sound_q(295), sound_q(295), sound_q(305),
        sound_q(324)
    };

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_OUT
    } state_t;

    // One breakpoint as read from the tables
    typedef struct packed {
        logic signed [DOM_W-1:0] dom;
        logic [RNG_W-1:0]        rng;
        logic                    last;
    } bp_t;

endpackage

// ----- src/piecewise_linear_table_interp_core.sv -----
// Channel  Valid      Ready      Word
// -------  ---------  ---------  -------------------------
// in       in_valid   in_ready   mode, altitude_q8
// out      out_valid  out_ready  value_q16
//
// One word at a time: in_ready is low from acceptance until the result
// is loaded into the output register.
// The time taken grows with the breakpoints scanned (up to 16) for end and
// exact hits; an interpolated point adds the prep, multiply and start states
// plus MAG_W (21) divider steps. The segment scan and the serial divider set it.
// Asynchronous active-low reset returns the sequencer to idle with no result held.
// A stalled output holds its word; the next input is taken meanwhile.
module piecewise_linear_table_interp_core
    import plti_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    mode,
    input  logic signed [ALT_W-1:0] altitude_q8,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [OUT_W-1:0]        value_q16
);

    state_t                  state_reg, state_next;
    logic                    sel_reg, sel_next;
    logic signed [ALT_W-1:0] x_reg, x_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic signed [DOM_W-1:0] d0_reg, d0_next;
    logic signed [DOM_W-1:0] d1_reg, d1_next;
    logic [RNG_W-1:0]        r0_reg, r0_next;
    logic [RNG_W-1:0]        r1_reg, r1_next;
    logic                    neg_reg, neg_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic [DD_W-1:0]         dx_reg, dx_next;
    logic [DD_W-1:0]         dd_reg, dd_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [RNG_W-1:0]        res_reg, res_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]        out_data_reg, out_data_next;

    bp_t                     bp;
    logic signed [CMP_W-1:0] x_c;
    logic signed [CMP_W-1:0] d_c;
    logic signed [CMP_W-1:0] dx_full;
    logic signed [DOM_W-1:0] dd_full;
    logic [RNG_W-1:0]        dr_abs;
    logic                    d_ge;
    logic                    d_eq;
    logic                    div_start;
    logic                    div_done;
    logic [MAG_W-1:0]        div_quot;
    logic [WIDE_W-1:0]       res_wide;

    plti_rom u_rom (
        .sel (sel_reg),
        .idx (idx_reg),
        .bp  (bp)
    );

    plti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dd_reg),
        .done     (div_done),
        .quot     (div_quot)
    );

    // Shared compare: current breakpoint against the altitude
    assign x_c  = CMP_W'(x_reg);
    assign d_c  = CMP_W'(bp.dom);
    assign d_ge = (d_c >= x_c);
    assign d_eq = (d_c == x_c);

    // Segment deltas
    assign dx_full = x_c - CMP_W'(d0_reg);
    assign dd_full = d1_reg - d0_reg;
    assign dr_abs  = (r1_reg < r0_reg) ? (r0_reg - r1_reg) : (r1_reg - r0_reg);

    assign res_wide  = WIDE_W'(res_reg);
    assign div_start = (state_reg == ST_START);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        x_next         = x_reg;
        idx_next       = idx_reg;
        d0_next        = d0_reg;
        d1_next        = d1_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        dx_next        = dx_reg;
        dd_next        = dd_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // Output register drains independently
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sel_next   = mode;
                    x_next     = altitude_q8;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    // At or below the first breakpoint
                    if (d_ge)
                    begin
                        res_next   = bp.rng;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        d0_next  = bp.dom;
                        r0_next  = bp.rng;
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                else if (d_eq)
                begin
                    res_next   = bp.rng;
                    state_next = ST_OUT;
                end
                else if (d_ge)
                begin
                    d1_next    = bp.dom;
                    r1_next    = bp.rng;
                    state_next = ST_PREP;
                end
                else if (bp.last)
                begin
                    // Beyond the last breakpoint
                    res_next   = bp.rng;
                    state_next = ST_OUT;
                end
                else
                begin
                    d0_next  = bp.dom;
                    r0_next  = bp.rng;
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_PREP:
            begin
                neg_next   = (r1_reg < r0_reg);
                mag_next   = dr_abs[MAG_W-1:0];
                dx_next    = dx_full[DD_W-1:0];
                dd_next    = dd_full[DD_W-1:0];
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(mag_reg) * PROD_W'(dx_reg);
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_next   = neg_reg ? (r0_reg - RNG_W'(div_quot))
                                         : (r0_reg + RNG_W'(div_quot));
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_wide[OUT_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        sel_reg      <= sel_next;
        x_reg        <= x_next;
        idx_reg      <= idx_next;
        d0_reg       <= d0_next;
        d1_reg       <= d1_next;
        r0_reg       <= r0_next;
        r1_reg       <= r1_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        dx_reg       <= dx_next;
        dd_reg       <= dd_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign value_q16 = out_data_reg;

endmodule

// ----- src/plti_rom.sv -----
module plti_rom
    import plti_pkg::*;
(
    input  logic             sel,
    input  logic [IDX_W-1:0] idx,
    output bp_t              bp
);

    int alt_m;

    // Breakpoint read; altitude scaled to the input format by a shift
    always_comb
    begin
        alt_m   = 0;
        bp.rng  = '0;
        bp.last = 1'b0;
        case (sel)
            SEL_GRAV:
            begin
                if (idx < IDX_W'(GRAV_N))
                begin
                    alt_m  = GRAV_ALT[idx];
                    bp.rng = GRAV_RNG[idx];
                end
                bp.last = (idx == IDX_W'(GRAV_N - 1));
            end
            SEL_SOUND:
            begin
                alt_m   = SOUND_ALT[idx];
                bp.rng  = SOUND_RNG[idx];
                bp.last = (idx == IDX_W'(SOUND_N - 1));
            end
            default:
            begin
                alt_m   = 0;
                bp.rng  = '0;
                bp.last = 1'b0;
            end
        endcase
        bp.dom = DOM_W'(alt_m) <<< IN_FRAC_BITS;
    end

endmodule

// ----- src/plti_div.sv -----
module plti_div
    import plti_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [DD_W-1:0]   divisor,
    output logic              done,
    output logic [MAG_W-1:0]  quot
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DD_W-1:0]   rem_reg, rem_next;
    logic [DD_W-1:0]   dvs_reg, dvs_next;
    // Low dividend bits shift out at the top, quotient bits enter at the bottom
    logic [MAG_W-1:0]  sh_reg, sh_next;

    logic [DD_W:0]     trial;
    logic [DD_W:0]     diff;
    logic              ge;

    // One restoring step: shift in a bit, subtract if it fits
    assign trial = {rem_reg, sh_reg[MAG_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        sh_next   = sh_reg;
        if (start)
        begin
            // Quotient fits MAG_W bits, so the high part is already below the divisor
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MAG_W);
            rem_next  = dividend[PROD_W-1:MAG_W];
            sh_next   = dividend[MAG_W-1:0];
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DD_W-1:0] : trial[DD_W-1:0];
            sh_next  = {sh_reg[MAG_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        sh_reg  <= sh_next;
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

// ----- src/plti_chk.sv -----
module plti_chk
    import plti_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    mode,
    input logic signed [ALT_W-1:0] altitude_q8,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [OUT_W-1:0]        value_q16
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_q16))
        else $error("output word changed while stalled");

    // One word in flight: no second acceptance right after the first
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // A result needs at least the scan step after acceptance
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

    // Loading a result frees the input side
    a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("input not ready after result load");

endmodule

bind piecewise_linear_table_interp_core plti_chk u_plti_chk (.*);

// ----- dv/piecewise_linear_table_interp_core_test.sv -----
module piecewise_linear_table_interp_core_test
    import plti_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Fixed-point formats of the lookup
    localparam int ALT_FRAC = 8;
    localparam int VAL_FRAC = 16;
    // Cycles with no word moving on either channel before giving up
    localparam int STALL_LIMIT = 3000;
    // Long receiver hold-off used to back the block up
    localparam int LONG_HOLD = 400;
    // Quiet cycles after the last result, covers the worst latency
    localparam int TAIL_CYCLES = 60;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    mode = SEL_GRAV;
    logic signed [ALT_W-1:0] altitude_q8 = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [OUT_W-1:0]        value_q16;

    // Breakpoint tables: gravity uses the first 14 altitudes, sound all 16
    int knot_alt_m  [16] = '{0, 1000, 2000, 3000, 4000, 5000, 6000, 7000, 8000, 9000,
                             10000, 15000, 20000, 25000, 30000, 40000};
    int grav_milli  [14] = '{9807, 9804, 9801, 9797, 9794, 9791, 9788, 9785, 9782,
                             9779, 9776, 9761, 9745, 9730};
    int sound_mps   [16] = '{340, 336, 332, 328, 324, 320, 316, 312, 308, 303, 299,
                             295, 295, 295, 305, 324};

    typedef struct {
        logic                    sel;
        logic signed [ALT_W-1:0] alt;
        logic [OUT_W-1:0]        value;
    } lookup_t;

    lookup_t pending_lookups [$];

    int  mismatches    = 0;
    int  results_seen  = 0;
    int  grav_words    = 0;
    int  sound_words   = 0;
    int  out_hold      = 0;
    bit  idling        = 1'b1;

    piecewise_linear_table_interp_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .altitude_q8 (altitude_q8),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value_q16   (value_q16)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Lookup predictor
    // ---------------------------------------------------------------

    function automatic int knot_count(input logic sel);
        return (sel == SEL_SOUND) ? 16 : 14;
    endfunction

    function automatic longint knot_alt(input int i);
        return longint'(knot_alt_m[i]) * (longint'(1) << ALT_FRAC);
    endfunction

    // Gravity rounds thousandths to nearest, ties up; sound is exact
    function automatic longint knot_val(input logic sel, input int i);
        if (sel == SEL_SOUND)
            return longint'(sound_mps[i]) << VAL_FRAC;
        return ((longint'(grav_milli[i]) << VAL_FRAC) + 500) / 1000;
    endfunction

    function automatic logic [OUT_W-1:0] interp_value(input logic sel,
                                                      input logic signed [ALT_W-1:0] alt);
        longint x;
        longint d0;
        longint d1;
        longint r0;
        longint r1;
        longint dr;
        longint step;
        longint v;
        int     n;
        int     i;
        x = longint'(alt);
        n = knot_count(sel);
        if (x <= knot_alt(0))
            v = knot_val(sel, 0);
        else if (x >= knot_alt(n - 1))
            v = knot_val(sel, n - 1);
        else
        begin
            // first breakpoint at or above the altitude
            i = 1;
            while (i < n - 1 && knot_alt(i) < x)
                i++;
            d1 = knot_alt(i);
            r1 = knot_val(sel, i);
            if (d1 == x)
                v = r1;
            else
            begin
                d0 = knot_alt(i - 1);
                r0 = knot_val(sel, i - 1);
                dr = r1 - r0;
                // magnitude divided, sign put back: truncates toward zero
                step = ((dr < 0) ? -dr : dr) * (x - d0) / (d1 - d0);
                v = (dr < 0) ? r0 - step : r0 + step;
            end
        end
        return v[OUT_W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic logic signed [ALT_W-1:0] pick_altitude(input logic sel);
        int     r;
        int     n;
        longint top;
        r   = $urandom_range(0, 99);
        n   = knot_count(sel);
        top = knot_alt(n - 1);
        if (r < 45)
            return ALT_W'($urandom_range(0, int'(top)));
        if (r < 60)
            return ALT_W'(knot_alt($urandom_range(0, n - 1)));
        if (r < 72)
        begin
            if ($urandom_range(0, 1) == 1)
                return ALT_W'(knot_alt($urandom_range(0, n - 1)) + $urandom_range(1, 4));
            return ALT_W'(knot_alt($urandom_range(0, n - 1)) - $urandom_range(1, 4));
        end
        if (r < 85)
            return $urandom;
        if (r < 93)
        begin
            if ($urandom_range(0, 1) == 1)
                return ALT_W'(top + $urandom_range(1, 1 << 20));
            return -ALT_W'($urandom_range(1, 1 << 20));
        end
        case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            default: return -32'sd1;
        endcase
    endfunction

    // Offer one word, wait for it to be taken, queue its expected value.
    // Valid is left high; callers that pause use release_input first.
    task automatic send_word(input logic sel, input logic signed [ALT_W-1:0] alt);
        int gap;
        gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode        <= sel;
        altitude_q8 <= alt;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_lookups.push_back('{sel: sel, alt: alt, value: interp_value(sel, alt)});
        if (sel == SEL_SOUND)
            sound_words++;
        else
            grav_words++;
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Sender pause until every expected result is back
    task automatic wait_drained();
        release_input();
        while (pending_lookups.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Table ends, extreme altitudes, exact hits and each segment shape
    task automatic test_directed_points();
        send_word(SEL_GRAV, 32'sh8000_0000);
        send_word(SEL_GRAV, -32'sd1);
        send_word(SEL_GRAV, 32'sd0);
        send_word(SEL_GRAV, 32'sd1);
        send_word(SEL_GRAV, 500 * 256 + 128);
        send_word(SEL_GRAV, 10000 * 256);
        send_word(SEL_GRAV, 12345 * 256 + 77);
        send_word(SEL_GRAV, 25000 * 256 - 1);
        send_word(SEL_GRAV, 25000 * 256);
        send_word(SEL_GRAV, 32'sh7fff_ffff);
        send_word(SEL_SOUND, 32'sh8000_0000);
        send_word(SEL_SOUND, -32'sd256);
        send_word(SEL_SOUND, 32'sd0);
        send_word(SEL_SOUND, 4000 * 256);
        send_word(SEL_SOUND, 8500 * 256 + 3);
        send_word(SEL_SOUND, 17000 * 256);
        send_word(SEL_SOUND, 35000 * 256 + 255);
        send_word(SEL_SOUND, 40000 * 256 - 1);
        send_word(SEL_SOUND, 40000 * 256);
        send_word(SEL_SOUND, 40000 * 256 + 1);
        send_word(SEL_SOUND, 32'sh7fff_ffff);
    endtask

    task automatic test_random_mix(input int count);
        logic sel;
        repeat (count)
        begin
            sel = 1'($urandom_range(0, 1));
            send_word(sel, pick_altitude(sel));
        end
    endtask

    // Receiver holds off while words keep coming, so the block backs up
    task automatic test_output_backpressure();
        bit saved;
        logic sel;
        saved    = idling;
        idling   = 1'b0;
        out_hold = LONG_HOLD;
        repeat (12)
        begin
            sel = 1'($urandom_range(0, 1));
            send_word(sel, pick_altitude(sel));
        end
        idling = saved;
        wait_drained();
    endtask

    // Small groups separated by full drains of the block
    task automatic test_drain_pauses();
        logic sel;
        repeat (4)
        begin
            repeat (10)
            begin
                sel = 1'($urandom_range(0, 1));
                send_word(sel, pick_altitude(sel));
            end
            wait_drained();
        end
    endtask

    // Closing stretch: both sides always ready
    task automatic test_streaming(input int count);
        idling = 1'b0;
        test_random_mix(count);
    endtask

    // ---------------------------------------------------------------
    // Result receiver: random bursts of back-pressure, or a long hold
    // ---------------------------------------------------------------
    initial
    begin : drive_out_ready
        int n;
        forever
        begin
            @(negedge clk);
            n = 0;
            if (out_hold > 0)
            begin
                n = out_hold;
                out_hold = 0;
            end
            else if (idling && $urandom_range(0, 3) == 0)
                n = $urandom_range(1, 11);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin : check_results
        lookup_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_lookups.size() == 0)
                report_mismatch($sformatf("result %h with nothing expected", value_q16));
            else
            begin
                e = pending_lookups.pop_front();
                results_seen++;
                if (value_q16 !== e.value)
                    report_mismatch($sformatf("mode %0d alt %0d: value_q16 %h, want %h",
                                              e.sel, e.alt, value_q16, e.value));
            end
        end
    end

    // Watchdog on cycles with no word moving
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_points();
        test_random_mix(1400);
        test_output_backpressure();
        test_drain_pauses();
        test_random_mix(100);
        test_streaming(260);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_lookups.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_lookups.size()));

        $display("Run covered %0d words (%0d gravity, %0d sound), %0d results checked,",
                 grav_words + sound_words, grav_words, sound_words, results_seen);
        $display("with table ends, breakpoints, full-range altitudes and a %0d-cycle stall.",
                 LONG_HOLD);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
